[hdl/izavg_pkg.sv]
// Shared constants, types and helpers for the 2x zoom with neighbor averaging.
// Used by every module of the block but izavg_ram; depends on nothing.
package izavg_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int REG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int OUT_DATA_W = 32;
    localparam int NUM_SLOTS  = 4;

    // Register index, taken from paddr[2]
    localparam logic REG_IDX_ROWS = 1'b0;
    localparam logic REG_IDX_COLS = 1'b1;

    // Result slots, in raster order of the enlarged image
    localparam logic [1:0] SLOT_CENTER = 2'd0;  // (2r-1, 2c-1)
    localparam logic [1:0] SLOT_UP     = 2'd1;  // (2r-1, 2c)
    localparam logic [1:0] SLOT_LEFT   = 2'd2;  // (2r,   2c-1)
    localparam logic [1:0] SLOT_OWN    = 2'd3;  // (2r,   2c)

    typedef logic [PIX_W-1:0] t_pix;

    // Accepted pixel waiting for its row-store read
    typedef struct packed {
        t_pix             pix;
        t_pix             left;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_end;
    } t_stage;

    // Up to four results of one pixel, ready for the output sequencer
    typedef struct packed {
        t_pix [NUM_SLOTS-1:0] value;
        logic [NUM_SLOTS-1:0] mask;
        logic [COORD_W-1:0]   row2;
        logic [COORD_W-1:0]   col2;
        logic                 frame_end;
    } t_job;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int eff_size(input logic [REG_W-1:0] v, input int maxv);
        int r;
        r = int'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

[hdl/izavg_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read and a write of the same entry return the old contents.
module izavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/izavg_blend.sv]
// Neighbor averaging for one source pixel: builds the four result values and their mask.
// Depends on izavg_pkg.
module izavg_blend (
    input  izavg_pkg::t_stage i_stage,
    input  izavg_pkg::t_pix   i_above_raw,
    input  izavg_pkg::t_pix   i_above_left,
    output izavg_pkg::t_job   o_job,
    output izavg_pkg::t_pix   o_above
);

    localparam int PW = izavg_pkg::PIX_W;

    logic            row_nz;
    logic            col_nz;
    izavg_pkg::t_pix above;
    logic [PW+1:0]   sum4;
    logic [PW:0]     sum_up;
    logic [PW:0]     sum_left;

    assign row_nz = (i_stage.row != '0);
    assign col_nz = (i_stage.col != '0);
    // The first row has nothing above it
    assign above  = row_nz ? i_above_raw : '0;

    assign sum4 = {2'b00, i_above_left} + {2'b00, above} + {2'b00, i_stage.left}
                + {2'b00, i_stage.pix} + (PW+2)'(2);
    assign sum_up   = {1'b0, above} + {1'b0, i_stage.pix} + (PW+1)'(1);
    assign sum_left = {1'b0, i_stage.left} + {1'b0, i_stage.pix} + (PW+1)'(1);

    always_comb begin
        o_job = '0;
        o_job.value[izavg_pkg::SLOT_CENTER] = sum4[PW+1:2];
        o_job.value[izavg_pkg::SLOT_UP]     = sum_up[PW:1];
        o_job.value[izavg_pkg::SLOT_LEFT]   = sum_left[PW:1];
        o_job.value[izavg_pkg::SLOT_OWN]    = i_stage.pix;
        o_job.mask[izavg_pkg::SLOT_CENTER]  = row_nz & col_nz;
        o_job.mask[izavg_pkg::SLOT_UP]      = row_nz;
        o_job.mask[izavg_pkg::SLOT_LEFT]    = col_nz;
        o_job.mask[izavg_pkg::SLOT_OWN]     = 1'b1;
        o_job.row2      = izavg_pkg::COORD_W'({i_stage.row, 1'b0});
        o_job.col2      = izavg_pkg::COORD_W'({i_stage.col, 1'b0});
        o_job.frame_end = i_stage.frame_end;
    end

    assign o_above = above;

endmodule

[hdl/izavg_emit.sv]
// Output sequencer: walks the valid result slots of one pixel and drives the
// registered result stream. Depends on izavg_pkg.
module izavg_emit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  izavg_pkg::t_job                      i_job,
    output logic                                 o_job_ready,
    output logic                                 o_tvalid,
    input  logic                                 i_tready,
    output logic [izavg_pkg::OUT_DATA_W-1:0]     o_tdata,
    output logic                                 o_tlast,
    output logic                                 o_tuser
);

    localparam int CW  = izavg_pkg::COORD_W;
    localparam int PAD = izavg_pkg::OUT_DATA_W - 2 * CW - izavg_pkg::PIX_W;

    izavg_pkg::t_job                    r_job;
    logic                               r_busy;
    logic [izavg_pkg::NUM_SLOTS-1:0]    r_pend;
    logic                               r_ovalid;
    logic [izavg_pkg::OUT_DATA_W-1:0]   r_odata;
    logic                               r_olast;
    logic                               r_ouser;

    logic [1:0]                         slot;
    logic [izavg_pkg::NUM_SLOTS-1:0]    rest;
    logic                               slot_last;
    logic                               can_emit;
    logic [CW-1:0]                      cur_row;
    logic [CW-1:0]                      cur_col;

    // Lowest pending slot goes first
    always_comb begin
        if (r_pend[izavg_pkg::SLOT_CENTER]) begin
            slot = izavg_pkg::SLOT_CENTER;
        end else if (r_pend[izavg_pkg::SLOT_UP]) begin
            slot = izavg_pkg::SLOT_UP;
        end else if (r_pend[izavg_pkg::SLOT_LEFT]) begin
            slot = izavg_pkg::SLOT_LEFT;
        end else begin
            slot = izavg_pkg::SLOT_OWN;
        end
    end

    always_comb begin
        rest       = r_pend;
        rest[slot] = 1'b0;
    end

    assign slot_last = (rest == '0);
    assign can_emit  = r_busy && (!r_ovalid || i_tready);
    assign o_job_ready = !r_busy || (can_emit && slot_last);

    // Upper row for the center and up slots, left column for center and left slots
    assign cur_row = (slot == izavg_pkg::SLOT_CENTER || slot == izavg_pkg::SLOT_UP)
                   ? r_job.row2 - CW'(1) : r_job.row2;
    assign cur_col = (slot == izavg_pkg::SLOT_CENTER || slot == izavg_pkg::SLOT_LEFT)
                   ? r_job.col2 - CW'(1) : r_job.col2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pend   <= '0;
        end else begin
            if (i_job_valid && o_job_ready) begin
                r_busy <= 1'b1;
                r_pend <= i_job.mask;
                r_job  <= i_job;
            end else if (can_emit) begin
                r_pend <= rest;
                if (slot_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (can_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload: load on emit, hold otherwise
    always_ff @(posedge i_clk) begin
        if (can_emit) begin
            r_odata <= {PAD'(0), r_job.value[slot], cur_col, cur_row};
            r_olast <= slot_last;
            r_ouser <= slot_last && r_job.frame_end;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_ouser;

endmodule

[hdl/image_zoom_2x_average.sv]
// Top level of the 2x image zoom with neighbor averaging: configuration
// registers, source counters, row store and pipeline. Depends on izavg_pkg,
// izavg_ram, izavg_blend and izavg_emit.
//
// Usage:
//   Source gray pixels enter in raster order on the s_axis channel, one
//   pixel per transaction in tdata[7:0]. Every pixel yields one, two or
//   four pixels of the (2R-1)x(2C-1) enlarged image on the m_axis channel,
//   in raster order of that image, each tagged with its row and column.
//   tlast marks the last result of a source pixel, tuser the last result
//   of the whole frame.
//   The APB port holds image_rows (index 0) and image_cols (index 1); any
//   write restarts the frame at source pixel (0,0). Write only while idle.
//   An accepted pixel passes the pipeline stage, the sequencer's job
//   register and the output register. Results leave at one per cycle
//   while m_axis_tready is high; a pixel yields one result at (0,0), two
//   elsewhere in the first row and column, four inside. The row store (one
//   read and one write per pixel, same address) never limits the rate.
//   Reset clears the counters, the pipeline and both sizes to one; the row
//   store is not cleared, since no entry's contents are used before the
//   previous row has written it.
//   A stall on m_axis holds the current result; one more pixel waits in
//   the pipeline stage and s_axis_tready drops until space frees up.
module image_zoom_2x_average (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Source pixels
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [7:0] pixel_in
    // Enlarged image
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [izavg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [10:0] out_row,
                                                                 // [21:11] out_col,
                                                                 // [29:22] out_value
    output logic                                 m_axis_tlast,   // last_of_run
    output logic                                 m_axis_tuser,   // [0] frame_done
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [izavg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [izavg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [izavg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int COL_W = izavg_pkg::COL_W;
    localparam int ROW_W = izavg_pkg::ROW_W;
    localparam int REG_W = izavg_pkg::REG_W;

    // Configuration
    logic [REG_W-1:0]  r_rows;
    logic [REG_W-1:0]  r_cols;
    logic              cfg_we;
    logic              reg_idx;

    // Source position and neighbors
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    izavg_pkg::t_pix   r_left;
    izavg_pkg::t_pix   r_above_left;
    logic [ROW_W:0]    eff_rows;
    logic [COL_W:0]    eff_cols;
    logic              col_wrap;
    logic              row_wrap;
    logic              accept;
    izavg_pkg::t_pix   pix_in;

    // Stage waiting on the row store read
    logic              r_s1_valid;
    izavg_pkg::t_stage r_s1;
    izavg_pkg::t_pix   above_raw;
    izavg_pkg::t_pix   above;
    izavg_pkg::t_job   job;
    logic              job_ready;
    logic              s1_move;

    // ---------------------------------------------------------------
    // APB registers: decode on paddr[2], pready tied high
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= REG_W'(1);
            r_cols <= REG_W'(1);
        end else if (cfg_we) begin
            if (reg_idx == izavg_pkg::REG_IDX_ROWS) begin
                r_rows <= pwdata[REG_W-1:0];
            end else begin
                r_cols <= pwdata[REG_W-1:0];
            end
        end
    end

    always_comb begin
        case (reg_idx)
            izavg_pkg::REG_IDX_ROWS: prdata = izavg_pkg::APB_DATA_W'(r_rows);
            izavg_pkg::REG_IDX_COLS: prdata = izavg_pkg::APB_DATA_W'(r_cols);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Source counters
    // ---------------------------------------------------------------
    assign eff_rows = (ROW_W+1)'(izavg_pkg::eff_size(r_rows, izavg_pkg::MAX_ROWS));
    assign eff_cols = (COL_W+1)'(izavg_pkg::eff_size(r_cols, izavg_pkg::MAX_COLS));
    assign col_wrap = ({1'b0, r_col} + (COL_W+1)'(1)) >= eff_cols;
    assign row_wrap = ({1'b0, r_row} + (ROW_W+1)'(1)) >= eff_rows;

    assign pix_in        = s_axis_tdata[izavg_pkg::PIX_W-1:0];
    assign s1_move       = r_s1_valid && job_ready;
    assign s_axis_tready = !r_s1_valid || job_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_left <= '0;
        end else if (cfg_we) begin
            // Any register write restarts the frame
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_left <= pix_in;
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Row store: read the pixel above and overwrite it with the new pixel
    // in the same cycle; the read-first port returns the previous row.
    // ---------------------------------------------------------------
    izavg_ram #(
        .WIDTH (izavg_pkg::PIX_W),
        .DEPTH (izavg_pkg::MAX_COLS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (pix_in),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (above_raw)
    );

    // Hold the accepted pixel until the sequencer takes its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pix       <= pix_in;
            r_s1.left      <= r_left;
            r_s1.row       <= r_row;
            r_s1.col       <= r_col;
            r_s1.frame_end <= col_wrap && row_wrap;
        end
    end

    // Above-left is the previous pixel's above value, advanced in pipeline order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above_left <= '0;
        end else if (s1_move) begin
            r_above_left <= above;
        end
    end

    izavg_blend u_blend (
        .i_stage      (r_s1),
        .i_above_raw  (above_raw),
        .i_above_left (r_above_left),
        .o_job        (job),
        .o_above      (above)
    );

    izavg_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_s1_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // The frame flag only rides on the last result of a pixel
    a_frame_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame_done without last_of_run");

    // The column counter stays inside the effective width
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < eff_cols))
        else $error("source column beyond image width");

    // The last pixel of a frame wraps both counters
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_wrap && row_wrap && !cfg_we) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not wrap at frame end");

endmodule
